### sv/aoas_pkg.sv
// aoas_pkg: shared types and constants of the operator absence alarm sequencer
// used by aoas_regs, aoas_seq and operator_absence_alarm_sequencer
`timescale 1ns / 1ps

package aoas_pkg;

    // register file geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // register indexes (paddr[4:2])
    typedef enum logic [2:0] {
        REG_REPEAT_LIMIT = 3'd0,
        REG_DELAY_ONE    = 3'd1,
        REG_DELAY_OTHER  = 3'd2,
        REG_BUZZ_RELAY   = 3'd3,
        REG_RELAY_TIME   = 3'd4,
        REG_BUZZ_LONG    = 3'd5
    } t_reg_idx;

    // reset values of the timing registers
    localparam logic [9:0] RST_REPEAT_LIMIT = 10'd1000;
    localparam logic [3:0] RST_DELAY_ONE    = 4'd2;
    localparam logic [3:0] RST_DELAY_OTHER  = 4'd3;
    localparam logic [3:0] RST_BUZZ_RELAY   = 4'd5;
    localparam logic [3:0] RST_RELAY_TIME   = 4'd5;
    localparam logic [3:0] RST_BUZZ_LONG    = 4'd7;

    // sequence phases
    typedef enum logic [2-1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_BUZZ  = 2'd2,
        PH_RELAY = 2'd3
    } t_phase;

    // switch patterns with the seat empty, 0 for none
    localparam logic [2:0] PAT_NONE              = 3'd0;
    localparam logic [2:0] PAT_HOLD_GEAR         = 3'd1;
    localparam logic [2:0] PAT_HOLD_NEUTRAL      = 3'd2;
    localparam logic [2:0] PAT_PTO_BRAKE_GEAR    = 3'd3;
    localparam logic [2:0] PAT_PTO_BRAKE_NEUTRAL = 3'd4;
    localparam logic [2:0] PAT_PTO_GEAR          = 3'd5;
    localparam logic [2:0] PAT_PTO_NEUTRAL       = 3'd6;

    // timing configuration
    typedef struct packed {
        logic [9:0] repeat_limit;
        logic [3:0] delay_pattern_one;
        logic [3:0] delay_other_patterns;
        logic [3:0] buzz_time_relay_patterns;
        logic [3:0] relay_time;
        logic [3:0] buzz_time_long;
    } t_cfg;

    // one switch sample
    typedef struct packed {
        logic seat_sense;
        logic pto_engaged;
        logic park_brake;
        logic gear_engaged;
        logic second_tick;
    } t_sample;

endpackage

### sv/operator_absence_alarm_sequencer.sv
// operator_absence_alarm_sequencer: top level with input and result registers
// depends on aoas_pkg, aoas_regs and aoas_seq
// path: an accepted sample word waits in the input register, and its result is captured in the result register
// throughput: one word per cycle while i_out_stall is low, set by the state update in aoas_seq
// reset (synchronous, active low): sequence idle, counts cleared, registers at defaults
// the input and result registers are empty after reset
`timescale 1ns / 1ps

module operator_absence_alarm_sequencer import aoas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_seat_sense,
    input  logic              i_pto_engaged,
    input  logic              i_park_brake,
    input  logic              i_gear_engaged,
    input  logic              i_second_tick,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_buzzer_on,
    output logic              o_relay_on,
    output logic [2:0]        o_active_pattern,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       w_cfg;
    t_sample    r_in;
    logic       r_in_valid;
    logic       r_out_valid;
    logic       r_buzzer_on;
    logic       r_relay_on;
    logic [2:0] r_active_pattern;
    logic       w_adv;
    logic       w_in_acc;
    logic       w_buzzer_on;
    logic       w_relay_on;
    logic [2:0] w_active_pattern;

    aoas_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    aoas_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_sample         (r_in),
        .i_cfg            (w_cfg),
        .o_buzzer_on      (w_buzzer_on),
        .o_relay_on       (w_relay_on),
        .o_active_pattern (w_active_pattern)
    );

    // handshake: the input word moves on when the result register is free
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.seat_sense   <= i_seat_sense;
            r_in.pto_engaged  <= i_pto_engaged;
            r_in.park_brake   <= i_park_brake;
            r_in.gear_engaged <= i_gear_engaged;
            r_in.second_tick  <= i_second_tick;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_buzzer_on      <= w_buzzer_on;
            r_relay_on       <= w_relay_on;
            r_active_pattern <= w_active_pattern;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_buzzer_on      = r_buzzer_on;
    assign o_relay_on       = r_relay_on;
    assign o_active_pattern = r_active_pattern;

endmodule

### sv/aoas_regs.sv
// aoas_regs: apb register file holding the sequence timing configuration
// depends on aoas_pkg
`timescale 1ns / 1ps

module aoas_regs import aoas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_limit             <= RST_REPEAT_LIMIT;
            r_cfg.delay_pattern_one        <= RST_DELAY_ONE;
            r_cfg.delay_other_patterns     <= RST_DELAY_OTHER;
            r_cfg.buzz_time_relay_patterns <= RST_BUZZ_RELAY;
            r_cfg.relay_time               <= RST_RELAY_TIME;
            r_cfg.buzz_time_long           <= RST_BUZZ_LONG;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_REPEAT_LIMIT: r_cfg.repeat_limit             <= pwdata[9:0];
                REG_DELAY_ONE:    r_cfg.delay_pattern_one        <= pwdata[3:0];
                REG_DELAY_OTHER:  r_cfg.delay_other_patterns     <= pwdata[3:0];
                REG_BUZZ_RELAY:   r_cfg.buzz_time_relay_patterns <= pwdata[3:0];
                REG_RELAY_TIME:   r_cfg.relay_time               <= pwdata[3:0];
                REG_BUZZ_LONG:    r_cfg.buzz_time_long           <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_REPEAT_LIMIT: prdata = {22'd0, r_cfg.repeat_limit};
            REG_DELAY_ONE:    prdata = {28'd0, r_cfg.delay_pattern_one};
            REG_DELAY_OTHER:  prdata = {28'd0, r_cfg.delay_other_patterns};
            REG_BUZZ_RELAY:   prdata = {28'd0, r_cfg.buzz_time_relay_patterns};
            REG_RELAY_TIME:   prdata = {28'd0, r_cfg.relay_time};
            REG_BUZZ_LONG:    prdata = {28'd0, r_cfg.buzz_time_long};
            default:          prdata = '0;
        endcase
    end

endmodule

### sv/aoas_seq.sv
// aoas_seq: sequence state registers and the single-pass step logic
// depends on aoas_pkg
`timescale 1ns / 1ps

module aoas_seq import aoas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_sample    i_sample,
    input  t_cfg       i_cfg,
    output logic       o_buzzer_on,
    output logic       o_relay_on,
    output logic [2:0] o_active_pattern
);

    typedef struct packed {
        t_phase     phase;
        logic [2:0] pattern;
        logic [2:0] last_pattern;
        logic [9:0] repeat_count;
        logic [3:0] seconds;
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] w_pat;
    logic [9:0] w_cnt;

    // decode switch levels into a pattern number, 0 for none
    function automatic logic [2:0] pattern_of(input t_sample s);
        logic [2:0] p;
        p = PAT_NONE;
        if (!s.seat_sense) begin
            if (!s.pto_engaged) begin
                if (s.park_brake) p = s.gear_engaged ? PAT_HOLD_GEAR : PAT_HOLD_NEUTRAL;
            end else if (s.park_brake) begin
                p = s.gear_engaged ? PAT_PTO_BRAKE_GEAR : PAT_PTO_BRAKE_NEUTRAL;
            end else begin
                p = s.gear_engaged ? PAT_PTO_GEAR : PAT_PTO_NEUTRAL;
            end
        end
        return p;
    endfunction

    // pass every phase whose time has been reached
    function automatic t_state advance(input t_state s, input t_cfg c);
        t_state     t;
        logic [3:0] d;
        t = s;
        d = (t.pattern == PAT_HOLD_GEAR) ? c.delay_pattern_one : c.delay_other_patterns;
        if (t.phase == PH_WAIT && t.seconds >= d) begin
            t.phase   = PH_BUZZ;
            t.seconds = 4'd0;
        end
        if (t.phase == PH_BUZZ) begin
            if (t.pattern == PAT_PTO_BRAKE_GEAR || t.pattern == PAT_PTO_BRAKE_NEUTRAL) begin
                if (t.seconds >= c.buzz_time_relay_patterns) begin
                    t.phase   = PH_RELAY;
                    t.seconds = 4'd0;
                end
            end else if (t.pattern == PAT_PTO_GEAR || t.pattern == PAT_PTO_NEUTRAL) begin
                if (t.seconds >= c.buzz_time_long) begin
                    t.phase   = PH_IDLE;
                    t.seconds = 4'd0;
                    t.pattern = PAT_NONE;
                end
            end
        end
        if (t.phase == PH_RELAY && t.seconds >= c.relay_time) begin
            t.phase   = PH_IDLE;
            t.seconds = 4'd0;
            t.pattern = PAT_NONE;
        end
        return t;
    endfunction

    assign w_pat = pattern_of(i_sample);

    // step: run or abort the current sequence, then try a start
    always_comb begin
        n_state = r_state;
        if (n_state.phase != PH_IDLE) begin
            if (w_pat != n_state.pattern) begin
                n_state.phase   = PH_IDLE;
                n_state.seconds = 4'd0;
                n_state.pattern = PAT_NONE;
            end else begin
                if (i_sample.second_tick && n_state.seconds != 4'hF) begin
                    n_state.seconds = n_state.seconds + 4'd1;
                end
                n_state = advance(n_state, i_cfg);
            end
        end
        w_cnt = (w_pat == n_state.last_pattern) ? n_state.repeat_count : 10'd0;
        if (n_state.phase == PH_IDLE && w_pat != PAT_NONE && w_cnt < i_cfg.repeat_limit) begin
            n_state.repeat_count = w_cnt + 10'd1;
            n_state.last_pattern = w_pat;
            n_state.pattern      = w_pat;
            n_state.seconds      = 4'd0;
            n_state.phase        = (w_pat == PAT_HOLD_NEUTRAL) ? PH_BUZZ : PH_WAIT;
            n_state = advance(n_state, i_cfg);
        end
    end

    // state register, updated once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.pattern      <= PAT_NONE;
            r_state.last_pattern <= PAT_NONE;
            r_state.repeat_count <= 10'd0;
            r_state.seconds      <= 4'd0;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    // result of this step
    assign o_buzzer_on      = (n_state.phase == PH_BUZZ);
    assign o_relay_on       = (n_state.phase == PH_RELAY);
    assign o_active_pattern = (n_state.phase == PH_IDLE) ? PAT_NONE : n_state.pattern;

endmodule
